// File: rtl/utf8_manuscript_style_checker_macros.svh
// ----------------------------------------------------------------------------
// utf8_manuscript_style_checker_macros.svh
// Assertion macros for the manuscript style checker. Simulation gets the
// checks; a synthesis run with SYNTH defined gets empty bodies.
// ----------------------------------------------------------------------------
`ifndef UTF8_MANUSCRIPT_STYLE_CHECKER_MACROS_SVH
`define UTF8_MANUSCRIPT_STYLE_CHECKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication on clk, masked during reset
`define USC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("usc assertion failed");
// next-cycle implication on clk, masked during reset
`define USC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usc assertion failed");
`else
`define USC_ASSERT_IMP(label, ante, cons)
`define USC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types and byte codes of the manuscript style checker.
// ----------------------------------------------------------------------------
package usc_pkg;

	// byte codes
	localparam logic [7:0] BYTE_LF        = 8'h0A;
	localparam logic [7:0] BYTE_CR        = 8'h0D;
	localparam logic [7:0] BYTE_LEAD_E3   = 8'hE3;
	localparam logic [7:0] BYTE_LEAD_E2   = 8'hE2;
	localparam logic [7:0] BYTE_MID_80    = 8'h80;
	localparam logic [7:0] BYTE_SPACE_80  = 8'h80;
	localparam logic [7:0] BYTE_OPEN_8C   = 8'h8C;
	localparam logic [7:0] BYTE_CLOSE_8D  = 8'h8D;
	localparam logic [7:0] BYTE_STOP_82   = 8'h82;
	localparam logic [7:0] BYTE_COMMA_81  = 8'h81;
	localparam logic [7:0] BYTE_ELLIP_A6  = 8'hA6;
	localparam logic [7:0] BYTE_DASH_94   = 8'h94;
	localparam logic [7:0] BYTE_DASH_95   = 8'h95;
	localparam logic [7:0] CONT_MASK      = 8'hC0;
	localparam logic [7:0] CONT_TAG       = 8'h80;

	// bytes of the line seen so far, saturating
	localparam int unsigned POS_W = 3;
	localparam logic [POS_W-1:0] POS_NONE  = 3'd0;
	localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
	localparam logic [POS_W-1:0] POS_THIRD = 3'd3;
	localparam logic [POS_W-1:0] POS_SAT   = 3'd4;

	localparam int unsigned HIST_DEPTH = 5;

	typedef enum logic [2:0] {
		ERR_ELLIPSIS = 3'd0,
		ERR_DASH     = 3'd1,
		ERR_DOUBLED  = 3'd2,
		ERR_BRACKET  = 3'd3,
		ERR_INDENT   = 3'd4
	} err_idx_e;

	localparam int unsigned ERR_KINDS = 5;

	typedef struct packed {
		logic extra_close;
		logic unclosed;
		logic doubled;
		logic indent;
		logic dash;
		logic ellipsis;
	} warn_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	// input stage to core and output stage
	typedef struct packed {
		logic  valid;
		logic  fire;
		item_t item;
	} step_t;

	// status from core to output stage
	typedef struct packed {
		warn_t warn;
		logic  is_final;
	} res_ctl_t;

endpackage

// File: rtl/usc_text_if.sv
// ----------------------------------------------------------------------------
// usc_text_if
// Text byte channel: valid/ready with one byte or an end marker.
// ----------------------------------------------------------------------------
interface usc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: rtl/usc_report_if.sv
// ----------------------------------------------------------------------------
// usc_report_if
// Report channel: warnings, line numbers and running counters per item.
// ----------------------------------------------------------------------------
interface usc_report_if #(
	parameter int unsigned LINE_WIDTH        = 20,
	parameter int unsigned ERROR_COUNT_WIDTH = 16,
	parameter int unsigned CHAR_COUNT_WIDTH  = 32
);
	logic                         valid;
	logic                         ready;
	logic [5:0]                   warn_flags;
	logic [LINE_WIDTH-1:0]        line_number;
	logic [LINE_WIDTH-1:0]        open_bracket_line;
	logic [CHAR_COUNT_WIDTH-1:0]  char_total;
	logic [ERROR_COUNT_WIDTH-1:0] ellipsis_errors;
	logic [ERROR_COUNT_WIDTH-1:0] dash_errors;
	logic [ERROR_COUNT_WIDTH-1:0] doubled_mark_errors;
	logic [ERROR_COUNT_WIDTH-1:0] bracket_errors;
	logic [ERROR_COUNT_WIDTH-1:0] indent_errors;
	logic                         is_final;

	modport source (
		output valid, output warn_flags, output line_number, output open_bracket_line,
		output char_total, output ellipsis_errors, output dash_errors,
		output doubled_mark_errors, output bracket_errors, output indent_errors,
		output is_final, input ready
	);
	modport sink (
		input valid, input warn_flags, input line_number, input open_bracket_line,
		input char_total, input ellipsis_errors, input dash_errors,
		input doubled_mark_errors, input bracket_errors, input indent_errors,
		input is_final, output ready
	);
endinterface

// File: rtl/usc_in_stage.sv
// ----------------------------------------------------------------------------
// usc_in_stage
// Input register: holds one text item until the result register can take it.
// ----------------------------------------------------------------------------
module usc_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	usc_text_if.sink       text_in,
	input  logic           advance,
	output usc_pkg::step_t step
);
	import usc_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// room when empty or when the held item moves on this cycle
	assign text_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.valid && text_in.ready) begin
			item_s1.text_byte   <= text_in.text_byte;
			item_s1.end_of_text <= text_in.end_of_text;
		end
	end

	assign step.valid = valid_s1;
	assign step.fire  = valid_s1 && advance;
	assign step.item  = item_s1;

endmodule

// File: rtl/usc_rule_core.sv
// ----------------------------------------------------------------------------
// usc_rule_core
// Style rule state and checks; updates once per item leaving the input stage.
// ----------------------------------------------------------------------------
module usc_rule_core #(
	parameter int unsigned LINE_WIDTH        = 20,
	parameter int unsigned ERROR_COUNT_WIDTH = 16,
	parameter int unsigned CHAR_COUNT_WIDTH  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  usc_pkg::step_t                step,
	output usc_pkg::res_ctl_t             res_ctl,
	output logic [LINE_WIDTH-1:0]         line_number,
	output logic [LINE_WIDTH-1:0]         open_bracket_line,
	output logic [CHAR_COUNT_WIDTH-1:0]   char_total,
	output logic [ERROR_COUNT_WIDTH-1:0]  err_total [usc_pkg::ERR_KINDS]
);
	import usc_pkg::*;

	`include "utf8_manuscript_style_checker_macros.svh"

	localparam logic [LINE_WIDTH-1:0] LINE_ONE = {{(LINE_WIDTH-1){1'b0}}, 1'b1};

	// state
	logic [7:0]                   recent_q [HIST_DEPTH];
	logic [LINE_WIDTH-1:0]        line_q;
	logic [POS_W-1:0]             pos_q;
	logic                         ell_par_q;
	logic                         dash_par_q;
	logic                         brk_open_q;
	logic [LINE_WIDTH-1:0]        opened_q;
	logic [CHAR_COUNT_WIDTH-1:0]  char_q;
	logic [ERROR_COUNT_WIDTH-1:0] err_q [ERR_KINDS];

	// next state
	logic [LINE_WIDTH-1:0]        line_nxt;
	logic [POS_W-1:0]             pos_nxt;
	logic                         ell_par_nxt;
	logic                         dash_par_nxt;
	logic                         brk_open_nxt;
	logic [LINE_WIDTH-1:0]        opened_nxt;
	logic [CHAR_COUNT_WIDTH-1:0]  char_nxt;
	logic [ERROR_COUNT_WIDTH-1:0] err_nxt [ERR_KINDS];
	logic [ERR_KINDS-1:0]         err_inc;
	logic                         char_inc;

	warn_t      warn;
	logic [7:0] b;
	logic [7:0] p1, p2, p3, p4, p5;
	logic       e3_80_prefix;
	logic       e2_80_prefix;

	assign b  = step.item.text_byte;
	assign p1 = recent_q[0];
	assign p2 = recent_q[1];
	assign p3 = recent_q[2];
	assign p4 = recent_q[3];
	assign p5 = recent_q[4];
	assign e3_80_prefix = (p2 == BYTE_LEAD_E3) && (p1 == BYTE_MID_80);
	assign e2_80_prefix = (p2 == BYTE_LEAD_E2) && (p1 == BYTE_MID_80);

	always_comb begin
		warn              = '0;
		err_inc           = '0;
		char_inc          = 1'b0;
		line_nxt          = line_q;
		pos_nxt           = pos_q;
		ell_par_nxt       = ell_par_q;
		dash_par_nxt      = dash_par_q;
		brk_open_nxt      = brk_open_q;
		opened_nxt        = opened_q;
		open_bracket_line = '0;

		if (step.item.end_of_text) begin
			warn.ellipsis          = ell_par_q;
			warn.dash              = dash_par_q;
			warn.unclosed          = brk_open_q;
			err_inc[ERR_ELLIPSIS]  = ell_par_q;
			err_inc[ERR_DASH]      = dash_par_q;
			err_inc[ERR_BRACKET]   = brk_open_q;
			open_bracket_line      = brk_open_q ? opened_q : '0;
		end else begin
			// line position / newline
			if (b == BYTE_LF) begin
				warn.ellipsis         = ell_par_q;
				warn.dash             = dash_par_q;
				err_inc[ERR_ELLIPSIS] = ell_par_q;
				err_inc[ERR_DASH]     = dash_par_q;
				ell_par_nxt           = 1'b0;
				dash_par_nxt          = 1'b0;
				if (line_q != '1) begin
					line_nxt = line_q + LINE_ONE;
				end
				pos_nxt = POS_NONE;
			end else if (b != BYTE_CR) begin
				if (pos_q < POS_SAT) begin
					pos_nxt = pos_q + POS_FIRST;
				end
			end

			// start of line: full-width space or opening bracket expected
			if (pos_nxt == POS_FIRST && b != BYTE_LEAD_E3) begin
				warn.indent = 1'b1;
			end else if (pos_nxt == POS_THIRD && p2 == BYTE_LEAD_E3) begin
				if (!(p1 == BYTE_MID_80 && (b == BYTE_SPACE_80 || b == BYTE_OPEN_8C))) begin
					warn.indent = 1'b1;
				end
			end
			err_inc[ERR_INDENT] = warn.indent;

			// doubled full stop or comma
			if (p5 == BYTE_LEAD_E3 && p4 == BYTE_MID_80 && e3_80_prefix && p3 == b &&
				(b == BYTE_COMMA_81 || b == BYTE_STOP_82)) begin
				warn.doubled         = 1'b1;
				err_inc[ERR_DOUBLED] = 1'b1;
			end

			// corner brackets
			if (e3_80_prefix && b == BYTE_OPEN_8C) begin
				warn.unclosed = brk_open_q;
				brk_open_nxt  = 1'b1;
				opened_nxt    = line_q;
			end
			if (e3_80_prefix && b == BYTE_CLOSE_8D) begin
				warn.extra_close = !brk_open_q;
				brk_open_nxt     = 1'b0;
			end
			err_inc[ERR_BRACKET] = warn.unclosed || warn.extra_close;

			char_inc = (b & CONT_MASK) != CONT_TAG;

			if (e2_80_prefix && b == BYTE_ELLIP_A6) begin
				ell_par_nxt = !ell_par_q;
			end
			if (e2_80_prefix && (b == BYTE_DASH_94 || b == BYTE_DASH_95)) begin
				dash_par_nxt = !dash_par_q;
			end

			if (warn.unclosed) begin
				open_bracket_line = opened_q;
			end else if (brk_open_nxt) begin
				open_bracket_line = opened_nxt;
			end
		end
	end

	// saturating counters
	always_comb begin
		char_nxt = char_q;
		if (char_inc && char_q != '1) begin
			char_nxt = char_q + {{(CHAR_COUNT_WIDTH-1){1'b0}}, 1'b1};
		end
		for (int k = 0; k < ERR_KINDS; k++) begin
			err_nxt[k] = err_q[k];
			if (err_inc[k] && err_q[k] != '1) begin
				err_nxt[k] = err_q[k] + {{(ERROR_COUNT_WIDTH-1){1'b0}}, 1'b1};
			end
		end
	end

	assign res_ctl.warn     = warn;
	assign res_ctl.is_final = step.item.end_of_text;
	assign line_number      = line_q;
	assign char_total       = char_nxt;
	assign err_total        = err_nxt;

	// end item reports, then returns everything to the reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HIST_DEPTH; k++) begin
				recent_q[k] <= '0;
			end
			line_q     <= LINE_ONE;
			pos_q      <= POS_NONE;
			ell_par_q  <= 1'b0;
			dash_par_q <= 1'b0;
			brk_open_q <= 1'b0;
			opened_q   <= '0;
			char_q     <= '0;
			for (int k = 0; k < ERR_KINDS; k++) begin
				err_q[k] <= '0;
			end
		end else if (step.fire) begin
			if (step.item.end_of_text) begin
				for (int k = 0; k < HIST_DEPTH; k++) begin
					recent_q[k] <= '0;
				end
				line_q     <= LINE_ONE;
				pos_q      <= POS_NONE;
				ell_par_q  <= 1'b0;
				dash_par_q <= 1'b0;
				brk_open_q <= 1'b0;
				opened_q   <= '0;
				char_q     <= '0;
				for (int k = 0; k < ERR_KINDS; k++) begin
					err_q[k] <= '0;
				end
			end else begin
				recent_q[0] <= b;
				for (int k = 1; k < HIST_DEPTH; k++) begin
					recent_q[k] <= recent_q[k-1];
				end
				line_q     <= line_nxt;
				pos_q      <= pos_nxt;
				ell_par_q  <= ell_par_nxt;
				dash_par_q <= dash_par_nxt;
				brk_open_q <= brk_open_nxt;
				opened_q   <= opened_nxt;
				char_q     <= char_nxt;
				for (int k = 0; k < ERR_KINDS; k++) begin
					err_q[k] <= err_nxt[k];
				end
			end
		end
	end

	`USC_ASSERT_IMP(a_line_nonzero, 1'b1, line_q != '0)
	`USC_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= POS_SAT)
	`USC_ASSERT_NEXT(a_final_clears, step.fire && step.item.end_of_text,
		line_q == LINE_ONE && char_q == '0 && !brk_open_q && pos_q == POS_NONE)
	`USC_ASSERT_NEXT(a_newline_restarts, step.fire && !step.item.end_of_text &&
		step.item.text_byte == BYTE_LF, pos_q == POS_NONE && !ell_par_q && !dash_par_q)

endmodule

// File: rtl/usc_out_stage.sv
// ----------------------------------------------------------------------------
// usc_out_stage
// Result register toward the report channel.
// ----------------------------------------------------------------------------
module usc_out_stage #(
	parameter int unsigned LINE_WIDTH        = 20,
	parameter int unsigned ERROR_COUNT_WIDTH = 16,
	parameter int unsigned CHAR_COUNT_WIDTH  = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  usc_pkg::step_t               step,
	input  usc_pkg::res_ctl_t            res_ctl,
	input  logic [LINE_WIDTH-1:0]        line_number,
	input  logic [LINE_WIDTH-1:0]        open_bracket_line,
	input  logic [CHAR_COUNT_WIDTH-1:0]  char_total,
	input  logic [ERROR_COUNT_WIDTH-1:0] err_total [usc_pkg::ERR_KINDS],
	output logic                         advance,
	usc_report_if.source                 report_out
);
	import usc_pkg::*;

	logic                         valid_q;
	warn_t                        warn_q;
	logic                         final_q;
	logic [LINE_WIDTH-1:0]        line_q;
	logic [LINE_WIDTH-1:0]        obl_q;
	logic [CHAR_COUNT_WIDTH-1:0]  char_q;
	logic [ERROR_COUNT_WIDTH-1:0] err_q [ERR_KINDS];

	// register free or draining this cycle
	assign advance = !valid_q || report_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fire) begin
			warn_q  <= res_ctl.warn;
			final_q <= res_ctl.is_final;
			line_q  <= line_number;
			obl_q   <= open_bracket_line;
			char_q  <= char_total;
			err_q   <= err_total;
		end
	end

	assign report_out.valid               = valid_q;
	assign report_out.warn_flags          = warn_q;
	assign report_out.line_number         = line_q;
	assign report_out.open_bracket_line   = obl_q;
	assign report_out.char_total          = char_q;
	assign report_out.ellipsis_errors     = err_q[ERR_ELLIPSIS];
	assign report_out.dash_errors         = err_q[ERR_DASH];
	assign report_out.doubled_mark_errors = err_q[ERR_DOUBLED];
	assign report_out.bracket_errors      = err_q[ERR_BRACKET];
	assign report_out.indent_errors       = err_q[ERR_INDENT];
	assign report_out.is_final            = final_q;

endmodule

// File: rtl/utf8_manuscript_style_checker.sv
// ----------------------------------------------------------------------------
// utf8_manuscript_style_checker
// Japanese manuscript style checks over a UTF-8 byte stream, one report
// item per input item.
// ----------------------------------------------------------------------------
//
//   channel     dir  handshake      payload
//   ----------  ---  -------------  ---------------------------------------
//   text_in     in   valid/ready    text_byte, end_of_text
//   report_out  out  valid/ready    warn_flags, line numbers, counters,
//                                   is_final
//
// One item per cycle while report_out is ready; each item passes the input
// register, then rule checks and state update into the result register.
// The rule core updates its state when an item leaves the input register,
// which happens whenever the result register is empty or being drained.
// A stall on report_out holds both registers; text_in.ready drops only when
// both hold an item.
// arst_n clears control state and rule state (line counter back to one);
// an end item reports, then restores the same reset state.
//
// Rule summary:
//   - indent: first byte of a line must lead a full-width char, and that
//     char must be the ideographic space or an opening corner bracket
//   - doubled ideographic full stop / comma back to back
//   - corner bracket balance; reopen while open counts as unclosed
//   - odd count of ellipses or dashes at line end or end of text
// All counters saturate at their maximum.
// ----------------------------------------------------------------------------
module utf8_manuscript_style_checker #(
	parameter int unsigned LINE_WIDTH        = 20,
	parameter int unsigned ERROR_COUNT_WIDTH = 16,
	parameter int unsigned CHAR_COUNT_WIDTH  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	usc_text_if.sink     text_in,
	usc_report_if.source report_out
);
	import usc_pkg::*;

	step_t                        step;
	res_ctl_t                     res_ctl;
	logic                         advance;
	logic [LINE_WIDTH-1:0]        line_number;
	logic [LINE_WIDTH-1:0]        open_bracket_line;
	logic [CHAR_COUNT_WIDTH-1:0]  char_total;
	logic [ERROR_COUNT_WIDTH-1:0] err_total [ERR_KINDS];

	// input register
	usc_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in),
		.advance (advance),
		.step    (step)
	);

	// rule state and checks
	usc_rule_core #(
		.LINE_WIDTH        (LINE_WIDTH),
		.ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH),
		.CHAR_COUNT_WIDTH  (CHAR_COUNT_WIDTH)
	) u_rule_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.res_ctl           (res_ctl),
		.line_number       (line_number),
		.open_bracket_line (open_bracket_line),
		.char_total        (char_total),
		.err_total         (err_total)
	);

	// result register
	usc_out_stage #(
		.LINE_WIDTH        (LINE_WIDTH),
		.ERROR_COUNT_WIDTH (ERROR_COUNT_WIDTH),
		.CHAR_COUNT_WIDTH  (CHAR_COUNT_WIDTH)
	) u_out_stage (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.res_ctl           (res_ctl),
		.line_number       (line_number),
		.open_bracket_line (open_bracket_line),
		.char_total        (char_total),
		.err_total         (err_total),
		.advance           (advance),
		.report_out        (report_out)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives UTF-8 text items into the manuscript style checker and checks every
// report item against a cycle-free predictor. The run covers a short directed
// manuscript and long random manuscripts. Both channels idle and stall at
// random, and the report side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import usc_pkg::*;

	localparam int unsigned LW = 20;   // line number width
	localparam int unsigned EW = 16;   // error counter width
	localparam int unsigned CW = 32;   // character counter width

	localparam int unsigned RANDOM_ITEMS = 1950;
	localparam int unsigned HOLD_AFTER   = 120;        // results before the long hold-off
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 8;          // two-stage pipe plus margin
	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam int unsigned PRINT_LIMIT  = 40;

	typedef enum logic [1:0] {
		RX_OPEN,      // always ready
		RX_SPARSE,    // stall one cycle in four, at random
		RX_PERIODIC,  // stall in a repeating pattern set by rx_cycle
		RX_HEAVY      // stall half the time
	} rx_mode_e;

	typedef struct packed {
		warn_t         warn;
		logic [LW-1:0] line;
		logic [LW-1:0] bracket_line;
		logic [CW-1:0] chars;
		logic [EW-1:0] ellipsis;
		logic [EW-1:0] dash;
		logic [EW-1:0] doubled;
		logic [EW-1:0] bracket;
		logic [EW-1:0] indent;
		logic          fin;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	usc_text_if text_ch ();
	usc_report_if #(.LINE_WIDTH(LW), .ERROR_COUNT_WIDTH(EW), .CHAR_COUNT_WIDTH(CW)) report_ch ();

	utf8_manuscript_style_checker #(
		.LINE_WIDTH(LW),
		.ERROR_COUNT_WIDTH(EW),
		.CHAR_COUNT_WIDTH(CW)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_ch),
		.report_out(report_ch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Stimulus and expectation stores
	// ------------------------------------------------------------------------
	item_t   text_items [$];    // items still to be offered, front is on the bus
	report_t reports_due [$];   // predicted reports, oldest first

	int unsigned mismatches   = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count  = 0;
	logic        in_taken     = 1'b0;   // an input item was accepted at the last rising edge

	// ------------------------------------------------------------------------
	// Predictor state: a plain copy of the checker's architectural state
	// ------------------------------------------------------------------------
	logic [7:0]       hist [HIST_DEPTH];   // newest byte first
	logic [LW-1:0]    line_ctr;
	logic [POS_W-1:0] line_pos;
	logic             ell_odd;
	logic             dash_odd;
	logic             bracket_held;
	logic [LW-1:0]    bracket_from;
	logic [CW-1:0]    char_ctr;
	logic [EW-1:0]    err_ctr [ERR_KINDS];

	function automatic void clear_checker_state();
		foreach (hist[i]) hist[i] = '0;
		line_ctr     = {{(LW-1){1'b0}}, 1'b1};
		line_pos     = POS_NONE;
		ell_odd      = 1'b0;
		dash_odd     = 1'b0;
		bracket_held = 1'b0;
		bracket_from = '0;
		char_ctr     = '0;
		foreach (err_ctr[i]) err_ctr[i] = '0;
	endfunction

	function automatic void bump_error(err_idx_e kind);
		if (err_ctr[kind] != '1)
			err_ctr[kind]++;
	endfunction

	// Works out the report for one accepted item and advances the state.
	function automatic report_t next_report(logic [7:0] b, logic eot);
		report_t       r;
		warn_t         w;
		logic [LW-1:0] line_now;
		logic [LW-1:0] prior_open;
		logic [LW-1:0] obl;
		logic [7:0]    p1, p2, p3, p4, p5;

		w        = '0;
		line_now = line_ctr;
		obl      = '0;

		if (eot) begin
			// end of text: pending parities and an open bracket all count
			if (ell_odd) begin
				w.ellipsis = 1'b1;
				bump_error(ERR_ELLIPSIS);
			end
			if (dash_odd) begin
				w.dash = 1'b1;
				bump_error(ERR_DASH);
			end
			if (bracket_held) begin
				w.unclosed = 1'b1;
				bump_error(ERR_BRACKET);
				obl = bracket_from;
			end
		end else begin
			p1 = hist[0];
			p2 = hist[1];
			p3 = hist[2];
			p4 = hist[3];
			p5 = hist[4];
			prior_open = bracket_from;

			if (b == BYTE_LF) begin
				if (ell_odd) begin
					w.ellipsis = 1'b1;
					bump_error(ERR_ELLIPSIS);
				end
				if (dash_odd) begin
					w.dash = 1'b1;
					bump_error(ERR_DASH);
				end
				ell_odd  = 1'b0;
				dash_odd = 1'b0;
				if (line_ctr != '1)
					line_ctr++;
				line_pos = POS_NONE;
			end else if (b != BYTE_CR) begin
				if (line_pos < POS_SAT)
					line_pos++;
			end

			// start of line: lead byte of a full-width char, then space or bracket.
			// A CR leaves the position alone, so the same check runs again.
			if (line_pos == POS_FIRST && b != BYTE_LEAD_E3) begin
				w.indent = 1'b1;
				bump_error(ERR_INDENT);
			end else if (line_pos == POS_THIRD && p2 == BYTE_LEAD_E3) begin
				if (!(p1 == BYTE_MID_80 && (b == BYTE_SPACE_80 || b == BYTE_OPEN_8C))) begin
					w.indent = 1'b1;
					bump_error(ERR_INDENT);
				end
			end

			if (p5 == BYTE_LEAD_E3 && p4 == BYTE_MID_80 && p2 == BYTE_LEAD_E3 &&
					p1 == BYTE_MID_80 && p3 == b && (b == BYTE_COMMA_81 || b == BYTE_STOP_82)) begin
				w.doubled = 1'b1;
				bump_error(ERR_DOUBLED);
			end

			// reopen while open counts as unclosed, the new line wins
			if (p2 == BYTE_LEAD_E3 && p1 == BYTE_MID_80 && b == BYTE_OPEN_8C) begin
				if (bracket_held) begin
					w.unclosed = 1'b1;
					bump_error(ERR_BRACKET);
				end
				bracket_held = 1'b1;
				bracket_from = line_ctr;
			end
			if (p2 == BYTE_LEAD_E3 && p1 == BYTE_MID_80 && b == BYTE_CLOSE_8D) begin
				if (!bracket_held) begin
					w.extra_close = 1'b1;
					bump_error(ERR_BRACKET);
				end else begin
					bracket_held = 1'b0;
				end
			end

			if ((b & CONT_MASK) != CONT_TAG && char_ctr != '1)
				char_ctr++;

			if (p2 == BYTE_LEAD_E2 && p1 == BYTE_MID_80 && b == BYTE_ELLIP_A6)
				ell_odd = ~ell_odd;
			if (p2 == BYTE_LEAD_E2 && p1 == BYTE_MID_80 &&
					(b == BYTE_DASH_94 || b == BYTE_DASH_95))
				dash_odd = ~dash_odd;

			for (int i = HIST_DEPTH - 1; i > 0; i--)
				hist[i] = hist[i-1];
			hist[0] = b;

			if (w.unclosed)
				obl = prior_open;
			else if (bracket_held)
				obl = bracket_from;
		end

		r.warn         = w;
		r.line         = line_now;
		r.bracket_line = obl;
		r.chars        = char_ctr;
		r.ellipsis     = err_ctr[ERR_ELLIPSIS];
		r.dash         = err_ctr[ERR_DASH];
		r.doubled      = err_ctr[ERR_DOUBLED];
		r.bracket      = err_ctr[ERR_BRACKET];
		r.indent       = err_ctr[ERR_INDENT];
		r.fin          = eot;

		if (eot)
			clear_checker_state();
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------------
	function automatic void queue_byte(logic [7:0] b);
		item_t it;
		it.text_byte   = b;
		it.end_of_text = 1'b0;
		text_items.push_back(it);
	endfunction

	// the byte field is don't-care on an end item, so it carries noise
	function automatic void queue_end();
		item_t it;
		it.text_byte   = 8'($urandom_range(0, 255));
		it.end_of_text = 1'b1;
		text_items.push_back(it);
	endfunction

	function automatic void queue_char3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		queue_byte(a);
		queue_byte(b);
		queue_byte(c);
	endfunction

	function automatic logic [7:0] rand_cont();
		return {2'b10, 6'($urandom_range(0, 63))};
	endfunction

	// One piece of manuscript text: marks, brackets, plain chars, and
	// now and then a broken or random sequence.
	function automatic void queue_random_token();
		case ($urandom_range(0, 15))
			0:       queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_STOP_82);
			1:       queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_COMMA_81);
			2:       queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_OPEN_8C);
			3:       queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_CLOSE_8D);
			4:       queue_char3(BYTE_LEAD_E2, BYTE_MID_80, BYTE_ELLIP_A6);
			5:       queue_char3(BYTE_LEAD_E2, BYTE_MID_80, BYTE_DASH_94);
			6:       queue_char3(BYTE_LEAD_E2, BYTE_MID_80, BYTE_DASH_95);
			7:       queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_SPACE_80);
			8:       queue_char3(8'($urandom_range(8'hE3, 8'hE9)), rand_cont(), rand_cont());
			9:       queue_byte(8'($urandom_range(8'h20, 8'h7E)));
			10:      queue_byte(BYTE_CR);
			11: begin
				// doubled stop or comma
				if ($urandom_range(0, 1)) begin
					queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_STOP_82);
					queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_STOP_82);
				end else begin
					queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_COMMA_81);
					queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_COMMA_81);
				end
			end
			12:      queue_char3(BYTE_LEAD_E3, BYTE_MID_80, 8'($urandom_range(0, 255)));
			13:      queue_char3(BYTE_LEAD_E2, BYTE_MID_80, rand_cont());
			14: begin
				// truncated sequence
				queue_byte(BYTE_LEAD_E3);
				if ($urandom_range(0, 1))
					queue_byte(BYTE_MID_80);
			end
			default: queue_byte(8'($urandom_range(0, 255)));
		endcase
	endfunction

	function automatic void queue_random_line();
		int unsigned n;
		n = $urandom_range(0, 10);
		if ($urandom_range(0, 9) == 0) begin
			// pure noise line
			repeat (n + 1) queue_byte(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_SPACE_80);
				5, 6, 7:       queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_OPEN_8C);
				8:             queue_byte(8'($urandom_range(8'h20, 8'h7E)));
				default:       ;   // line starts straight with a random token
			endcase
			repeat (n) queue_random_token();
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: queue_byte(BYTE_LF);
			6, 7, 8: begin
				queue_byte(BYTE_CR);
				queue_byte(BYTE_LF);
			end
			default: ;   // line runs on
		endcase
		if ($urandom_range(0, 29) == 0)
			queue_end();
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (mismatches < PRINT_LIMIT)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Rising edge: predict for the accepted input item first, then check the
	// accepted report item against the oldest prediction.
	always @(posedge clk) begin
		report_t want;
		report_t got;
		if (arst_n) begin
			if (text_ch.valid && text_ch.ready)
				reports_due.push_back(next_report(text_ch.text_byte, text_ch.end_of_text));
			in_taken <= text_ch.valid && text_ch.ready;

			if (report_ch.valid && report_ch.ready) begin
				results_seen <= results_seen + 1;
				got.warn         = warn_t'(report_ch.warn_flags);
				got.line         = report_ch.line_number;
				got.bracket_line = report_ch.open_bracket_line;
				got.chars        = report_ch.char_total;
				got.ellipsis     = report_ch.ellipsis_errors;
				got.dash         = report_ch.dash_errors;
				got.doubled      = report_ch.doubled_mark_errors;
				got.bracket      = report_ch.bracket_errors;
				got.indent       = report_ch.indent_errors;
				got.fin          = report_ch.is_final;
				if (reports_due.size() == 0) begin
					if (mismatches < PRINT_LIMIT)
						$display("%0t: unexpected report item, expected none, actual %0h",
							$time, got);
					mismatches++;
				end else begin
					want = reports_due.pop_front();
					check_field("warn_flags",          32'(want.warn),         32'(got.warn));
					check_field("line_number",         32'(want.line),         32'(got.line));
					check_field("open_bracket_line",   32'(want.bracket_line), 32'(got.bracket_line));
					check_field("char_total",          32'(want.chars),        32'(got.chars));
					check_field("ellipsis_errors",     32'(want.ellipsis),     32'(got.ellipsis));
					check_field("dash_errors",         32'(want.dash),         32'(got.dash));
					check_field("doubled_mark_errors", 32'(want.doubled),      32'(got.doubled));
					check_field("bracket_errors",      32'(want.bracket),      32'(got.bracket));
					check_field("indent_errors",       32'(want.indent),       32'(got.indent));
					check_field("is_final",            32'(want.fin),          32'(got.fin));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver: bursts of random length with random gaps, changes on falling edge
	// ------------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(negedge clk) begin
		logic  offer;
		item_t nxt;
		if (arst_n) begin
			offer = text_ch.valid;
			if (in_taken) begin
				void'(text_items.pop_front());
				offer = 1'b0;
				if (burst_left > 0)
					burst_left--;
			end
			// a held item stays on the bus untouched until it is taken
			if (!offer) begin
				if (burst_left == 0) begin
					if ($urandom_range(0, 19) == 0) begin
						burst_left = 300;   // long stretch with no idling
						gap_left   = 0;
					end else begin
						burst_left = $urandom_range(1, 32);
						gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
					end
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (text_items.size() > 0) begin
					nxt = text_items[0];
					offer = 1'b1;
					text_ch.text_byte   <= nxt.text_byte;
					text_ch.end_of_text <= nxt.end_of_text;
				end
			end
			text_ch.valid <= offer;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: stall pattern of its own, plus one long hold-off that fills
	// the pipe and pushes back on the text channel
	// ------------------------------------------------------------------------
	int unsigned rx_cycle  = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	always @(negedge clk) begin
		logic take;
		rx_cycle++;
		if (hold_left > 0) begin
			take = 1'b0;
			hold_left--;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			take      = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			hold_done = 1'b1;
		end else begin
			case (rx_mode_e'((rx_cycle / 97) % 4))
				RX_OPEN:     take = 1'b1;
				RX_SPARSE:   take = ($urandom_range(0, 3) != 0);
				RX_PERIODIC: take = ((rx_cycle % 5) != 0);
				default:     take = ($urandom_range(0, 1) != 0);
			endcase
		end
		report_ch.ready <= take;
	end

	// ------------------------------------------------------------------------
	// Timeout
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence: build all stimulus, reset, wait for drain, report
	// ------------------------------------------------------------------------
	initial begin
		int unsigned start;

		text_ch.valid       = 1'b0;
		text_ch.text_byte   = '0;
		text_ch.end_of_text = 1'b0;
		report_ch.ready     = 1'b0;
		clear_checker_state();

		// directed manuscript
		// line 1: bracket as indent, one ellipsis, doubled full stop
		queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_OPEN_8C);
		queue_char3(BYTE_LEAD_E2, BYTE_MID_80, BYTE_ELLIP_A6);
		queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_STOP_82);
		queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_STOP_82);
		queue_byte(BYTE_LF);
		// line 2: no indent, CR repeats the first-byte check, close then
		// extra close, one dash
		queue_byte(8'h41);
		queue_byte(BYTE_CR);
		queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_CLOSE_8D);
		queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_CLOSE_8D);
		queue_char3(BYTE_LEAD_E2, BYTE_MID_80, BYTE_DASH_95);
		queue_byte(BYTE_LF);
		// line 3: open, reopen while open, then end of text with it open
		queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_OPEN_8C);
		queue_char3(BYTE_LEAD_E3, BYTE_MID_80, BYTE_OPEN_8C);
		queue_byte(8'hFF);
		queue_end();

		// random manuscripts
		start = text_items.size();
		while (text_items.size() - start < RANDOM_ITEMS)
			queue_random_line();
		queue_char3(BYTE_LEAD_E2, BYTE_MID_80, BYTE_DASH_94);
		queue_end();

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		while (text_items.size() != 0 || reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
